// ===== sv/rlc_pkg.sv =====
// rlc_pkg: shared constants, types and helpers for the radix letter converter.
// Used by every module of the block; depends on nothing.
package rlc_pkg;

  // Default sizes
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // Radix register
  localparam int RADIX_W = 5;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd26;
  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd4;

  // Digits and letters
  localparam int DIGIT_W = 5;
  localparam int LETTER_W = 7;
  localparam logic [LETTER_W-1:0] LETTER_A = 7'd65;

  // Quotient bits retired per divider cycle
  localparam int DIV_STEP = 4;

  // Entries in the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

  // Hold a written radix inside the legal range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

endpackage

// ===== sv/rlc_queue.sv =====
// rlc_queue: small first-in first-out queue that decouples the front from the back.
// Depends on rlc_pkg for its depth.
module rlc_queue #(
  parameter int WIDTH = rlc_pkg::VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = rlc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== sv/rlc_divider.sv =====
// rlc_divider: iterative divider by a small radix, several quotient bits per cycle.
// Depends on rlc_pkg for radix and digit widths and the step size.
module rlc_divider #(
  parameter int VALUE_BITS = rlc_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [VALUE_BITS-1:0]       dividend_i,
  input  logic [rlc_pkg::RADIX_W-1:0] radix_i,
  output rlc_pkg::div_stat_t          stat_o,
  output logic [VALUE_BITS-1:0]       quotient_o
);

  localparam int STEP     = rlc_pkg::DIV_STEP;
  localparam int PAD_BITS = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int ITERS    = PAD_BITS / STEP;
  localparam int CNT_W    = $clog2(ITERS + 1);
  localparam int REM_W    = rlc_pkg::DIGIT_W;

  logic [PAD_BITS-1:0] work_q, work_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;

  // Restoring division over STEP bits: shift in, compare, subtract
  always_comb begin
    logic [PAD_BITS-1:0] w;
    logic [REM_W-1:0]    r;
    logic [REM_W:0]      t;
    w = work_q;
    r = rem_q;
    t = '0;
    for (int i = 0; i < STEP; i++) begin
      t = {r, w[PAD_BITS-1]};
      w = {w[PAD_BITS-2:0], 1'b0};
      if (t >= {1'b0, radix_i}) begin
        r    = REM_W'(t - {1'b0, radix_i});
        w[0] = 1'b1;
      end else begin
        r = t[REM_W-1:0];
      end
    end
    work_d = w;
    rem_d  = r;
  end

  // Hold dividend and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PAD_BITS'(dividend_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  // Count iterations and flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ITERS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];

endmodule

// ===== sv/rlc_back.sv =====
// rlc_back: sequencer that forms digits with the divider, stacks them and
// emits letters most significant first. Depends on rlc_pkg and rlc_divider.
module rlc_back #(
  parameter int VALUE_BITS = rlc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rlc_pkg::RADIX_W-1:0] radix_i,
  input  logic                        req_valid_i,
  input  logic [VALUE_BITS-1:0]       req_value_i,
  output logic                        req_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rlc_pkg::LETTER_W-1:0] out_letter_o,
  output logic                        out_last_o
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_OUT
  } state_e;

  state_e                       state_q;
  logic [VALUE_BITS-1:0]        cur_q;
  logic                         div_start_q;
  logic [CNT_W-1:0]             n_q;
  logic [IDX_W-1:0]             idx_q;
  logic [rlc_pkg::DIGIT_W-1:0]  rd_q;
  logic [rlc_pkg::DIGIT_W-1:0]  stack_q [MAX_DIGITS];
  rlc_pkg::div_stat_t           div_stat;
  logic [VALUE_BITS-1:0]        quotient;
  logic                         push;
  logic                         stop;

  rlc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (cur_q),
    .radix_i    (radix_i),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign push      = (state_q == S_DIV) && div_stat.done;
  assign stop      = (quotient == '0) || (n_q == CNT_W'(MAX_DIGITS - 1));
  assign req_pop_o = (state_q == S_IDLE) && req_valid_i;

  // Digit stack: push during division, registered read during emission
  always_ff @(posedge clk_i) begin
    if (push) stack_q[n_q[IDX_W-1:0]] <= div_stat.rem;
    if (state_q == S_RD) rd_q <= stack_q[idx_q];
  end

  // Sequence: divide until quotient is zero or the stack is full, then pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      cur_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            cur_q       <= req_value_i;
            n_q         <= '0;
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            n_q <= n_q + 1'b1;
            if (stop) begin
              idx_q   <= n_q[IDX_W-1:0];
              state_q <= S_RD;
            end else begin
              cur_q       <= quotient;
              div_start_q <= 1'b1;
            end
          end
        end
        S_RD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = (state_q == S_OUT);
  assign out_letter_o = rlc_pkg::LETTER_A + rlc_pkg::LETTER_W'(rd_q);
  assign out_last_o   = (idx_q == '0);

endmodule

// ===== sv/radix_letter_converter.sv =====
// Radix letter converter: one value in, its digits out as letters 'A'+digit.
// Each digit is formed by the divider; the letters are then read out of the digit
// stack read port, most significant first, each held until the output takes it.
// Values are converted one at a time; a two-entry queue takes new values meanwhile.
// Reset: rst_ni is asynchronous, active low; radix returns to 4, queue empties.
module radix_letter_converter #(
  parameter int VALUE_BITS = rlc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Radix register write
  input  logic                              cfg_we_i,
  input  logic [rlc_pkg::RADIX_W-1:0]       cfg_wdata_i,
  // Input requests
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // [VALUE_BITS-1:0] value
  // Output letters
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [6:0] letter, [7] zero
  output logic                              m_axis_tlast    // last_digit
);

  logic [rlc_pkg::RADIX_W-1:0]  radix_q;
  logic                         q_full;
  logic                         q_valid;
  logic                         q_pop;
  logic [VALUE_BITS-1:0]        q_value;
  logic [rlc_pkg::LETTER_W-1:0] letter;

  // Hold the clamped radix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rlc_pkg::RADIX_RST;
    end else if (cfg_we_i) begin
      radix_q <= rlc_pkg::clamp_radix(cfg_wdata_i);
    end
  end

  // Front: take requests into the queue while it has room
  assign s_axis_tready = !q_full;

  rlc_queue #(
    .WIDTH (VALUE_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (s_axis_tdata[VALUE_BITS-1:0]),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_value)
  );

  // Back: convert and emit
  rlc_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_i      (radix_q),
    .req_valid_i  (q_valid),
    .req_value_i  (q_value),
    .req_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_letter_o (letter),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, letter};

`ifndef SYNTHESIS
  // Radix never leaves the legal range
  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    radix_q >= rlc_pkg::RADIX_MIN && radix_q <= rlc_pkg::RADIX_MAX)
    else $error("radix out of range");

  // A write lands clamped
  a_radix_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> radix_q == rlc_pkg::clamp_radix($past(cfg_wdata_i)))
    else $error("radix write not clamped");

  // Every letter is a digit below the current radix
  a_letter_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] >= rlc_pkg::LETTER_A) &&
      ({1'b0, m_axis_tdata[6:0]} < {1'b0, rlc_pkg::LETTER_A} + 8'(radix_q)))
    else $error("letter outside digit range");
`endif

endmodule

// ===== test/tb_radix_letter_converter.sv =====
// Testbench for radix_letter_converter: drives values over the request stream,
// predicts the letter stream per radix, and checks each letter and end mark.
// Depends on rlc_pkg and the radix_letter_converter RTL only.
module tb_radix_letter_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W = rlc_pkg::VALUE_BITS_DEF;
  localparam int DIGIT_LIMIT = rlc_pkg::MAX_DIGITS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_LIMIT = 30;

  typedef struct {
    logic [rlc_pkg::LETTER_W-1:0] letter;
    logic                         last_digit;
  } letter_t;

  // Predict letters per request and compare them against the output stream
  class letter_scoreboard;
    logic [rlc_pkg::RADIX_W-1:0] radix;
    letter_t                     pending[$];
    int                          mismatches;

    function new();
      radix = rlc_pkg::RADIX_RST;
      mismatches = 0;
    endfunction

    // Hold the radix inside its legal range, like the block does
    function void set_radix(input logic [rlc_pkg::RADIX_W-1:0] wdata);
      if (wdata < rlc_pkg::RADIX_MIN) begin
        radix = rlc_pkg::RADIX_MIN;
      end else if (wdata > rlc_pkg::RADIX_MAX) begin
        radix = rlc_pkg::RADIX_MAX;
      end else begin
        radix = wdata;
      end
    endfunction

    // Split a value into digits, least significant first, then queue them reversed
    function void note_request(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0]          quot;
      logic [VALUE_W-1:0]          rem;
      logic [rlc_pkg::DIGIT_W-1:0] digits[$];
      logic [rlc_pkg::DIGIT_W-1:0] d;
      letter_t                     item;
      quot = value;
      do begin
        rem = quot % radix;
        digits.push_back(rem[rlc_pkg::DIGIT_W-1:0]);
        quot = quot / radix;
      end while (quot != 0 && digits.size() < DIGIT_LIMIT);
      while (digits.size() > 0) begin
        d = digits.pop_back();
        item.letter = rlc_pkg::LETTER_A + d;
        item.last_digit = (digits.size() == 0);
        pending.push_back(item);
      end
    endfunction

    task report(input string msg);
      if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one output letter with the oldest predicted one
    task check_result(input logic [7:0] data, input logic last);
      letter_t want;
      if (pending.size() == 0) begin
        report($sformatf("letter 0x%02h arrived with nothing outstanding", data));
        return;
      end
      want = pending.pop_front();
      if (data !== {1'b0, want.letter})
        report($sformatf("letter 0x%02h, want 0x%02h", data, want.letter));
      if (last !== want.last_digit)
        report($sformatf("end mark %b, want %b", last, want.last_digit));
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [rlc_pkg::RADIX_W-1:0] cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [VALUE_W-1:0]          s_axis_tdata;   // [31:0] value
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;   // [6:0] letter, [7] zero
  logic                        m_axis_tlast;   // last_digit

  letter_scoreboard sb;
  bit               idle_on;
  int               idle_cycles;

  radix_letter_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Observe both handshakes and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready === 1'b1) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAIL radix_letter_converter");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Accept letters; while idle_on is set, stall a random number of cycles before each one
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
    end
  end

  // Offer one request, after a random gap while idle_on is set; return at the edge that takes it
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  // Drop valid, then wait for every predicted letter and let the block settle
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [rlc_pkg::RADIX_W-1:0] wdata);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= wdata;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_radix(wdata);
  endtask

  // Mix of full-range, small, shortened, near-power-of-radix and near-maximum values
  function automatic logic [VALUE_W-1:0] pick_value(input logic [rlc_pkg::RADIX_W-1:0] r);
    longint unsigned    pw;
    int                 k;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 2 * r * r);
      2: v = $urandom >> $urandom_range(0, 31);
      3: begin
        pw = 1;
        k = $urandom_range(1, 32);
        repeat (k) if (pw * r <= 64'hFFFF_FFFF) pw = pw * r;
        v = pw[VALUE_W-1:0] - $urandom_range(0, 1);
      end
      default: v = 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  initial begin
    logic [rlc_pkg::RADIX_W-1:0] wdata;
    sb = new();
    idle_cycles = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset radix: zero, small values, top bit, all ones
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    drain();

    // Radix below range clamps to 2; all ones and the top bit give the longest numbers
    write_radix(5'd0);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    drain();

    // Radix above range clamps to 26; top digit 'Z'
    write_radix(5'd31);
    send_value(32'd25);
    send_value(32'd26);
    send_value(32'd675);
    send_value(32'd676);
    send_value(32'hFFFF_FFFF);
    drain();

    write_radix(5'd1);
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);
    drain();

    write_radix(5'd27);
    send_value(32'd0);
    send_value(32'd17575);
    drain();

    write_radix(5'd26);
    send_value(32'd17576);
    drain();

    // Random phases, each under its own radix
    for (int phase = 0; phase < 6; phase++) begin
      idle_on = (phase != 2 && phase != 5);
      case (phase)
        0: wdata = 5'd2;
        1: wdata = 5'd26;
        3: wdata = 5'd10;
        5: wdata = $urandom_range(3, 25);
        default: wdata = $urandom_range(0, 31);
      endcase
      write_radix(wdata);
      for (int i = 0; i < 20; i++) begin
        send_value(pick_value(sb.radix));
        // hold off new requests until the output catches up
        if (phase == 3 && i == 9) drain();
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("PASS radix_letter_converter");
    end else begin
      $display("FAIL radix_letter_converter");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rlc_pkg.sv
sv/rlc_queue.sv
sv/rlc_divider.sv
sv/rlc_back.sv
sv/radix_letter_converter.sv
test/tb_radix_letter_converter.sv
